>>> src/dmsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmsr_pkg
// Shared types and constants of the soft-reversal motor controller.
// ----------------------------------------------------------------------------
package dmsr_pkg;

    localparam int ADC_BITS   = 10;
    localparam int ADC_MAX    = (1 << ADC_BITS) - 1;
    localparam int NUM_W      = ADC_BITS + 8;
    localparam int K_W        = 14;
    localparam int DUTY_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // reciprocal estimates, always rounded down
    localparam int SH_SMALL = 16;
    localparam int SH_MAX   = ADC_BITS + 10;
    localparam logic [K_W-1:0] K_TEN  = K_W'((1 << SH_SMALL) / 10);
    localparam logic [K_W-1:0] K_FIVE = K_W'((1 << SH_SMALL) / 5);
    localparam logic [K_W-1:0] K_MAX  = K_W'((1 << SH_MAX) / ADC_MAX);

    localparam logic [CFG_IDX_W-1:0] REG_START_SPEED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RUN_SPEED   = CFG_IDX_W'(1);

    localparam logic [DUTY_W-1:0] START_SPEED_RST = DUTY_W'(125);
    localparam logic [DUTY_W-1:0] RUN_SPEED_RST   = DUTY_W'(65);
    localparam logic [DUTY_W-1:0] MARGIN_TICK     = DUTY_W'(5);
    localparam logic [DUTY_W-1:0] MARGIN_STEP     = DUTY_W'(4);
    localparam logic [DUTY_W-1:0] RAMP_CLOSE      = DUTY_W'(4);

    typedef enum logic [1:0] {
        DIV_BY_TEN,
        DIV_BY_MAX,
        DIV_BY_FIVE
    } t_div_sel;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DOWN,
        PH_UP
    } t_phase;

    typedef struct packed {
        logic     div_start;
        t_div_sel div_sel;
        logic     take_pot;
        logic     take_speed;
        logic     button;
        logic     take_ramp;
        logic     run_eval;
        logic     emit;
        logic     emit_last;
    } t_cmd;

    typedef struct packed {
        logic   div_done;
        logic   out_free;
        t_phase phase;
    } t_stat;

endpackage
`default_nettype wire

>>> src/dmsr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmsr_div
// Shared constant divider: reciprocal estimate, remainder, then correction
// steps until the remainder falls below the divisor.
// ----------------------------------------------------------------------------
module dmsr_div
    import dmsr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_div_sel         i_sel,
    input  wire logic [NUM_W-1:0] i_num,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quo
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_EST,
        D_REM,
        D_FIX
    } t_dstate;

    t_dstate            r_state;
    t_div_sel           r_sel;
    logic [NUM_W-1:0]   r_num;
    logic [NUM_W-1:0]   r_q;
    logic [NUM_W-1:0]   r_rem;
    logic               r_done;

    logic [K_W-1:0]            w_k;
    logic [ADC_BITS-1:0]       w_den;
    logic [NUM_W+K_W-1:0]      w_prod;
    logic [NUM_W-1:0]          w_est;
    logic [NUM_W+ADC_BITS-1:0] w_qd;

    always_comb begin
        case (r_sel)
            DIV_BY_TEN: begin
                w_k   = K_TEN;
                w_den = ADC_BITS'(10);
            end
            DIV_BY_FIVE: begin
                w_k   = K_FIVE;
                w_den = ADC_BITS'(5);
            end
            DIV_BY_MAX: begin
                w_k   = K_MAX;
                w_den = ADC_BITS'(ADC_MAX);
            end
            default: begin
                w_k   = K_TEN;
                w_den = ADC_BITS'(10);
            end
        endcase
    end

    assign w_prod = (NUM_W+K_W)'(r_num) * (NUM_W+K_W)'(w_k);
    assign w_est  = (r_sel == DIV_BY_MAX) ? NUM_W'(w_prod >> SH_MAX)
                                          : NUM_W'(w_prod >> SH_SMALL);
    assign w_qd   = (NUM_W+ADC_BITS)'(r_q) * (NUM_W+ADC_BITS)'(w_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_state <= D_EST;
                    end
                end
                D_EST: begin
                    r_state <= D_REM;
                end
                D_REM: begin
                    r_state <= D_FIX;
                end
                D_FIX: begin
                    if (r_rem < NUM_W'(w_den)) begin
                        r_state <= D_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_num <= i_num;
                    r_sel <= i_sel;
                end
            end
            D_EST: begin
                r_q <= w_est;
            end
            D_REM: begin
                r_rem <= r_num - w_qd[NUM_W-1:0];
            end
            D_FIX: begin
                if (r_rem >= NUM_W'(w_den)) begin
                    r_q   <= r_q + NUM_W'(1);
                    r_rem <= r_rem - NUM_W'(w_den);
                end
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule
`default_nettype wire

>>> src/dmsr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmsr_dp
// Datapath: configuration, motor state, ramp value, divider and output word.
// ----------------------------------------------------------------------------
module dmsr_dp
    import dmsr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_accept,
    input  wire logic [ADC_BITS-1:0]   i_adc_sample,
    input  wire logic                  i_button_level,
    input  wire logic                  i_stall,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    output logic                       o_valid,
    output logic [DUTY_W-1:0]          o_duty,
    output logic                       o_reverse,
    output logic                       o_last_of_run
);

    logic [DUTY_W-1:0]   r_start_speed;
    logic [DUTY_W-1:0]   r_run_speed;
    logic [ADC_BITS-1:0] r_adc;
    logic                r_level;
    logic [ADC_BITS-1:0] r_pot;
    logic [DUTY_W-1:0]   r_speed;
    logic [DUTY_W-1:0]   r_rep;
    logic                r_prev;
    logic                r_dir;
    logic                r_stop;
    logic [DUTY_W-1:0]   r_c;
    logic [DUTY_W-1:0]   r_target;
    t_phase              r_phase;
    logic                r_o_valid;
    logic [DUTY_W-1:0]   r_o_duty;
    logic                r_o_rev;
    logic                r_o_last;

    logic [DUTY_W-1:0] w_r;
    logic [DUTY_W:0]   w_span;
    logic [NUM_W-1:0]  w_num;
    logic              w_div_done;
    logic [NUM_W-1:0]  w_quo;
    logic [DUTY_W-1:0] w_q8;
    logic [DUTY_W-1:0] w_speed_new;

    function automatic logic far_off(input logic [DUTY_W-1:0] v,
                                     input logic [DUTY_W-1:0] rep,
                                     input logic [DUTY_W-1:0] margin);
        logic [DUTY_W-1:0] d;
        d = (v > rep) ? (v - rep) : (rep - v);
        return d > margin;
    endfunction

    assign w_r    = (r_run_speed == '0) ? DUTY_W'(1) : r_run_speed;
    assign w_span = (DUTY_W+1)'(256) - (DUTY_W+1)'(w_r);
    assign w_q8   = w_quo[DUTY_W-1:0];
    assign w_speed_new = w_q8 + w_r - DUTY_W'(1);

    always_comb begin
        case (i_cmd.div_sel)
            DIV_BY_TEN:  w_num = NUM_W'(r_adc) + (NUM_W'(r_pot) << 3) + NUM_W'(r_pot);
            DIV_BY_MAX:  w_num = NUM_W'(r_pot) * NUM_W'(w_span);
            DIV_BY_FIVE: w_num = (NUM_W'(r_c) << 2)
                               + ((r_phase == PH_UP) ? NUM_W'(r_target) : NUM_W'(0));
            default:     w_num = '0;
        endcase
    end

    dmsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_sel   (i_cmd.div_sel),
        .i_num   (w_num),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_speed <= START_SPEED_RST;
            r_run_speed   <= RUN_SPEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_SPEED: r_start_speed <= i_cfg_data;
                REG_RUN_SPEED:   r_run_speed   <= i_cfg_data;
                default:         r_run_speed   <= r_run_speed;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_adc   <= i_adc_sample;
            r_level <= i_button_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pot     <= '0;
            r_speed   <= '0;
            r_rep     <= '0;
            r_prev    <= 1'b0;
            r_dir     <= 1'b0;
            r_stop    <= 1'b1;
            r_c       <= '0;
            r_target  <= '0;
            r_phase   <= PH_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.take_pot) begin
                r_pot <= w_quo[ADC_BITS-1:0];
            end
            if (i_cmd.take_speed) begin
                r_speed <= w_speed_new;
                if (far_off(w_speed_new, r_rep, MARGIN_TICK)) begin
                    r_rep <= w_speed_new;
                end
            end
            if (i_cmd.button && (r_prev != r_level)) begin
                r_prev <= r_level;
                if (r_level) begin
                    if (r_stop) begin
                        r_dir <= ~r_dir;
                    end else begin
                        r_c      <= r_speed;
                        r_target <= (r_start_speed > r_speed) ? r_start_speed : r_speed;
                        r_phase  <= PH_DOWN;
                    end
                end
            end
            if (i_cmd.take_ramp) begin
                if (r_phase == PH_DOWN) begin
                    r_c <= w_q8;
                    if (w_q8 <= DUTY_W'(1)) begin
                        r_stop  <= 1'b1;
                        r_dir   <= ~r_dir;
                        r_phase <= PH_UP;
                    end
                end else if ({1'b0, w_q8} + {1'b0, RAMP_CLOSE} >= {1'b0, r_target}) begin
                    r_c     <= r_speed;
                    r_phase <= PH_IDLE;
                end else begin
                    r_c <= w_q8;
                end
            end
            if (i_cmd.run_eval) begin
                if (r_speed < w_r) begin
                    r_c    <= '0;
                    r_stop <= 1'b1;
                end else if ((r_rep > r_speed) && !r_stop) begin
                    r_c <= r_speed;
                end else if (r_stop && (r_speed > w_r)) begin
                    r_stop <= 1'b0;
                    r_c    <= r_start_speed;
                end else begin
                    r_c <= r_speed;
                end
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
                if (far_off(r_c, r_rep, MARGIN_STEP)) begin
                    r_rep <= r_c;
                end
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_duty <= r_c;
            r_o_rev  <= r_dir;
            r_o_last <= i_cmd.emit_last;
        end
    end

    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = !r_o_valid || !i_stall;
    assign o_stat.phase    = r_phase;

    assign o_valid       = r_o_valid;
    assign o_duty        = r_o_duty;
    assign o_reverse     = r_o_rev;
    assign o_last_of_run = r_o_last;

endmodule
`default_nettype wire

>>> src/dmsr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmsr_ctrl
// Tick sequencer: smoothing, speed map, button, reversal ramp, run rule.
// ----------------------------------------------------------------------------
module dmsr_ctrl
    import dmsr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_stat i_stat,
    output logic       o_stall,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_POT_WAIT,
        S_SPD_GO,
        S_SPD_WAIT,
        S_BUTTON,
        S_BRANCH,
        S_PHASE,
        S_RAMP_WAIT,
        S_EMIT_RAMP,
        S_RAMP_NEXT,
        S_EMIT_LAST
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= '0;
        end else begin
            r_cmd <= '0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd.div_start <= 1'b1;
                        r_cmd.div_sel   <= DIV_BY_TEN;
                        r_state         <= S_POT_WAIT;
                    end
                end
                S_POT_WAIT: begin
                    if (i_stat.div_done) begin
                        r_cmd.take_pot <= 1'b1;
                        r_state        <= S_SPD_GO;
                    end
                end
                S_SPD_GO: begin
                    r_cmd.div_start <= 1'b1;
                    r_cmd.div_sel   <= DIV_BY_MAX;
                    r_state         <= S_SPD_WAIT;
                end
                S_SPD_WAIT: begin
                    if (i_stat.div_done) begin
                        r_cmd.take_speed <= 1'b1;
                        r_state          <= S_BUTTON;
                    end
                end
                S_BUTTON: begin
                    r_cmd.button <= 1'b1;
                    r_state      <= S_BRANCH;
                end
                S_BRANCH: begin
                    r_state <= S_PHASE;
                end
                S_PHASE: begin
                    if (i_stat.phase == PH_IDLE) begin
                        r_cmd.run_eval <= 1'b1;
                        r_state        <= S_EMIT_LAST;
                    end else begin
                        r_cmd.div_start <= 1'b1;
                        r_cmd.div_sel   <= DIV_BY_FIVE;
                        r_state         <= S_RAMP_WAIT;
                    end
                end
                S_RAMP_WAIT: begin
                    if (i_stat.div_done) begin
                        r_cmd.take_ramp <= 1'b1;
                        r_state         <= S_EMIT_RAMP;
                    end
                end
                S_EMIT_RAMP: begin
                    if (i_stat.out_free) begin
                        r_cmd.emit <= 1'b1;
                        r_state    <= S_RAMP_NEXT;
                    end
                end
                S_RAMP_NEXT: begin
                    if (i_stat.phase == PH_IDLE) begin
                        r_cmd.run_eval <= 1'b1;
                        r_state        <= S_EMIT_LAST;
                    end else begin
                        r_cmd.div_start <= 1'b1;
                        r_cmd.div_sel   <= DIV_BY_FIVE;
                        r_state         <= S_RAMP_WAIT;
                    end
                end
                S_EMIT_LAST: begin
                    if (i_stat.out_free) begin
                        r_cmd.emit      <= 1'b1;
                        r_cmd.emit_last <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_cmd   = r_cmd;

endmodule
`default_nettype wire

>>> src/dc_motor_soft_reversal_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dc_motor_soft_reversal_controller
// One input word per control tick: a pot sample and the button level.
// Each tick yields one or more result words (duty, direction, last_of_run).
// A rising button edge on a running motor adds a soft reversal ramp of
// roughly forty words before the final word of the tick.
// Input channel: i_valid / o_stall; a word is taken when valid and not stall.
// Output channel: o_valid / i_stall through an output register, so the final
// word of one tick may wait while the next input word is already taken.
// Timing is set by the shared constant divider (estimate, remainder and at
// most one correction step per division).
// One tick is worked at a time; o_stall is high until the sequencer issues
// the command that places its last word in the output register.
// A stall on the output holds the current word and the sequence waits.
// Reset: motor stopped, direction forward, registers at start 125, run 65.
// Configuration writes are taken at any edge with i_cfg_we high and reset released.
// ----------------------------------------------------------------------------
module dc_motor_soft_reversal_controller
    import dmsr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [ADC_BITS-1:0]   i_adc_sample,
    input  wire logic                  i_button_level,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [DUTY_W-1:0]          o_duty,
    output logic                       o_reverse,
    output logic                       o_last_of_run
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_stall;
    logic  w_in_accept;

    assign w_in_accept = i_valid && !w_stall;
    assign o_stall     = w_stall;

    dmsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_stall (w_stall),
        .o_cmd   (w_cmd)
    );

    dmsr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_accept    (w_in_accept),
        .i_adc_sample   (i_adc_sample),
        .i_button_level (i_button_level),
        .i_stall        (i_stall),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_valid        (o_valid),
        .o_duty         (o_duty),
        .o_reverse      (o_reverse),
        .o_last_of_run  (o_last_of_run)
    );

endmodule
`default_nettype wire

>>> src/dmsr_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmsr_chk
// Port-level checks of the soft-reversal controller, bound to the top level.
// ----------------------------------------------------------------------------
module dmsr_chk
    import dmsr_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_cfg_we,
    input wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input wire logic                  i_valid,
    input wire logic                  o_stall,
    input wire logic [ADC_BITS-1:0]   i_adc_sample,
    input wire logic                  i_button_level,
    input wire logic                  o_valid,
    input wire logic                  i_stall,
    input wire logic [DUTY_W-1:0]     o_duty,
    input wire logic                  o_reverse,
    input wire logic                  o_last_of_run
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word present after reset");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_duty) && $stable(o_reverse)
                               && $stable(o_last_of_run))
        else $error("stalled output word changed");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again before tick finished");

    a_ramp_word_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> o_stall)
        else $error("ramp word pending while input is open");

endmodule

bind dc_motor_soft_reversal_controller dmsr_chk u_chk (.*);
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the soft-reversal motor controller: feeds control
// ticks through the valid/stall input, predicts every duty word (ramps
// included) and compares each word leaving the output channel in order.
// ----------------------------------------------------------------------------
module tb_top;
    import dmsr_pkg::*;

    localparam int MAX_WORDS   = 48;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int REPORT_MAX  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    typedef struct {
        logic [ADC_BITS-1:0] adc;
        logic                btn;
    } t_tick;

    typedef struct {
        logic [DUTY_W-1:0] duty;
        logic              rev;
        logic              last;
    } t_word;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_valid        = 1'b0;
    logic                  o_stall;
    logic [ADC_BITS-1:0]   i_adc_sample   = '0;
    logic                  i_button_level = 1'b0;
    logic                  o_valid;
    logic                  i_stall        = 1'b0;
    logic [DUTY_W-1:0]     o_duty;
    logic                  o_reverse;
    logic                  o_last_of_run;

    dc_motor_soft_reversal_controller u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_adc_sample   (i_adc_sample),
        .i_button_level (i_button_level),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_duty         (o_duty),
        .o_reverse      (o_reverse),
        .o_last_of_run  (o_last_of_run)
    );

    always #2 i_clk = ~i_clk;

    // controller model state and register copies
    int unsigned pot_avg     = 0;
    int unsigned shown_speed = 0;
    logic        btn_seen    = 1'b0;
    logic        dir_rev     = 1'b0;
    logic        motor_idle  = 1'b1;
    int unsigned kick_duty   = START_SPEED_RST;
    int unsigned min_run     = RUN_SPEED_RST;

    t_tick tick_pending[$];
    t_word tick_words[$];
    t_word duty_expect[$];

    int send_idle_pct = 26;
    int recv_idle_pct = 26;
    bit hold_go       = 1'b0;
    bit hold_used     = 1'b0;
    int hold_left     = 0;

    int ticks_taken    = 0;
    int words_checked  = 0;
    int ramps_seen     = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    logic btn_drive    = 1'b0;

    function automatic void note_level(input int unsigned v, input int unsigned margin);
        int unsigned d;
        d = (v > shown_speed) ? v - shown_speed : shown_speed - v;
        if (d > margin)
            shown_speed = v & 8'hFF;
    endfunction

    function automatic void emit_duty(input int unsigned duty);
        t_word w;
        w.duty = duty[DUTY_W-1:0];
        w.rev  = dir_rev;
        w.last = 1'b0;
        if (tick_words.size() < MAX_WORDS)
            tick_words.push_back(w);
        note_level(duty, MARGIN_STEP);
    endfunction

    function automatic void predict_tick(input logic [ADC_BITS-1:0] adc, input logic btn);
        int unsigned r;
        int unsigned speed;
        int unsigned target;
        int unsigned c;
        bit          ramp_on;
        bit          going_down;
        r = (min_run == 0) ? 1 : min_run;
        tick_words.delete();
        pot_avg = ((adc + 9 * pot_avg) / 10) & ADC_MAX;
        speed   = (pot_avg * (256 - r)) / ADC_MAX + (r - 1);
        note_level(speed, MARGIN_TICK);

        if (btn_seen != btn) begin
            btn_seen = btn;
            if (btn) begin
                if (motor_idle) begin
                    dir_rev = ~dir_rev;
                end else begin
                    ramps_seen++;
                    target     = (kick_duty > speed) ? kick_duty : speed;
                    c          = speed;
                    ramp_on    = 1'b1;
                    going_down = 1'b1;
                    while (ramp_on) begin
                        if (going_down) begin
                            c = (4 * c) / 5;
                            if (c <= 1) begin
                                motor_idle = 1'b1;
                                dir_rev    = ~dir_rev;
                                going_down = 1'b0;
                            end
                        end else begin
                            c = (4 * c + target) / 5;
                            if (c + RAMP_CLOSE >= target) begin
                                c       = speed;
                                ramp_on = 1'b0;
                            end
                        end
                        emit_duty(c);
                    end
                end
            end
        end

        if (speed < r) begin
            emit_duty(0);
            motor_idle = 1'b1;
        end else if (shown_speed > speed && !motor_idle) begin
            emit_duty(speed);
        end else if (motor_idle && speed > r) begin
            motor_idle = 1'b0;
            emit_duty(kick_duty);
        end else begin
            emit_duty(speed);
        end

        tick_words[tick_words.size() - 1].last = 1'b1;
        foreach (tick_words[i])
            duty_expect.push_back(tick_words[i]);
    endfunction

    function automatic void add_tick(input int adc, input logic btn);
        t_tick t;
        t.adc = adc[ADC_BITS-1:0];
        t.btn = btn;
        tick_pending.push_back(t);
    endfunction

    function automatic logic [ADC_BITS-1:0] pick_adc(input int level);
        int v;
        case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = ADC_MAX;
            2, 3:    v = int'($urandom_range(0, ADC_MAX));
            default: v = level + int'($urandom_range(0, 80)) - 40;
        endcase
        if (v < 0)
            v = 0;
        if (v > ADC_MAX)
            v = ADC_MAX;
        return v[ADC_BITS-1:0];
    endfunction

    function automatic void fill_random(input int count);
        int level;
        level = int'($urandom_range(200, ADC_MAX));
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0)
                level = int'($urandom_range(0, ADC_MAX));
            if ($urandom_range(0, 99) < 30)
                btn_drive = ~btn_drive;
            add_tick(pick_adc(level), btn_drive);
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_START_SPEED)
            kick_duty = data;
        else if (idx == REG_RUN_SPEED)
            min_run = data;
    endtask

    task automatic drain();
        while (tick_pending.size() != 0 || i_valid || duty_expect.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // input word driver
    always @(posedge i_clk) begin
        t_tick t;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                predict_tick(i_adc_sample, i_button_level);
                ticks_taken++;
            end
            if (tick_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t = tick_pending.pop_front();
                i_valid        <= 1'b1;
                i_adc_sample   <= t.adc;
                i_button_level <= t.btn;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output word monitor and receiver stall
    always @(posedge i_clk) begin
        t_word want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (duty_expect.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected word: duty %0d rev %0b last %0b",
                                 o_duty, o_reverse, o_last_of_run);
                end else begin
                    want = duty_expect.pop_front();
                    if (o_duty !== want.duty || o_reverse !== want.rev
                            || o_last_of_run !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("word %0d: expected duty %0d rev %0b last %0b, got duty %0d rev %0b last %0b",
                                     words_checked, want.duty, want.rev, want.last,
                                     o_duty, o_reverse, o_last_of_run);
                    end
                end
                words_checked++;
            end
            if (hold_go && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
                i_stall   <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed ticks at reset settings
        add_tick(0, 1'b0);
        add_tick(0, 1'b1);
        add_tick(0, 1'b0);
        repeat (4) add_tick(ADC_MAX, 1'b0);
        add_tick(ADC_MAX, 1'b1);
        add_tick(ADC_MAX, 1'b0);
        add_tick(ADC_MAX, 1'b1);
        add_tick(ADC_MAX, 1'b1);
        add_tick(10'h2AA, 1'b0);
        add_tick(10'h155, 1'b1);
        add_tick(ADC_MAX, 1'b0);
        repeat (4) add_tick(0, 1'b0);
        add_tick(512, 1'b1);
        add_tick(ADC_MAX, 1'b0);
        add_tick(ADC_MAX, 1'b1);
        drain();

        // extremes, long stretch without idling
        write_reg(REG_START_SPEED, 8'd255);
        write_reg(REG_RUN_SPEED, 8'd1);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        fill_random(50);
        drain();

        send_idle_pct <= 26;
        recv_idle_pct <= 26;
        write_reg(REG_START_SPEED, 8'd0);
        write_reg(REG_RUN_SPEED, 8'd255);
        fill_random(25);
        drain();

        // run speed zero; spare indexes must be ignored
        write_reg(REG_RUN_SPEED, 8'd0);
        write_reg(REG_START_SPEED, CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(REG_SPARE_2, CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(REG_SPARE_3, CFG_DATA_W'($urandom_range(0, 255)));
        fill_random(50);
        drain();

        // mid settings with a long receiver hold-off
        write_reg(REG_START_SPEED, CFG_DATA_W'($urandom_range(1, 254)));
        write_reg(REG_RUN_SPEED, CFG_DATA_W'($urandom_range(30, 120)));
        hold_go <= 1'b1;
        fill_random(65);
        drain();

        repeat (60) @(posedge i_clk);
        mismatch_count += duty_expect.size();
        $display("ran %0d ticks, checked %0d duty words including %0d reversal ramps,",
                 ticks_taken, words_checked, ramps_seen);
        $display("over five register settings with random stalls and one long hold-off");
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> dc_motor_soft_reversal_controller.f
src/dmsr_pkg.sv
src/dmsr_div.sv
src/dmsr_dp.sv
src/dmsr_ctrl.sv
src/dc_motor_soft_reversal_controller.sv
src/dmsr_chk.sv
tb/tb_top.sv
